// ----- hdl/chunky_to_planar_mapper_defines.svh -----
// Assertion macros used by the mapper's top-level RTL file.
`ifndef CHUNKY_TO_PLANAR_MAPPER_DEFINES_SVH
`define CHUNKY_TO_PLANAR_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/cpm_pkg.sv -----
`timescale 1ns / 1ps
package cpm_pkg;

	localparam int MAX_WIDTH  = 320;
	localparam int MAX_HEIGHT = 200;

	localparam int COL_W    = 9;
	localparam int ROW_W    = 8;
	localparam int PIX_W    = 8;
	localparam int COLOR_W  = 4;
	localparam int WORD_W   = 16;
	localparam int ADDR_W   = 14;
	localparam int PLANES   = 4;
	localparam int PLANE_W  = 2;
	localparam int MAP_DEPTH = 256;

	// Register indexes on the configuration port
	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CMD_PIXEL       = 2'd0,
		CMD_MAP_WRITE   = 2'd1,
		CMD_MAP_RESTORE = 2'd2
	} command_t;

endpackage

// ----- hdl/cpm_ram.sv -----
`timescale 1ns / 1ps
module cpm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read-first: a read and a write to the same address return the old entry.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/chunky_to_planar_mapper.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Contents
// cfg       in         cfg_we               cfg_index, cfg_data
// s_axis    in         s_tvalid / s_tready  tuser command, tdata pixel and map colour
// m_axis    out        m_tvalid / m_tready  tdata plane word and address, tuser plane, frame end
//
// One word is taken every cycle unless the input stage stalls; each item passes one input
// stage, where the map RAM read lands, and then commits into the plane accumulators and
// counters. A completed group of 16 pixels loads a four-word output buffer that drains one
// word per cycle while m_tready is high. A group completion stalls the input stage only while
// the previous burst is still in that buffer. Reset restores the identity map at once through
// per-entry valid bits and clears the counters; a configuration write restarts the frame.
`include "chunky_to_planar_mapper_defines.svh"
module chunky_to_planar_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] pixel_value, [11:8] map_color, [15:12] zero
	input  logic [1:0]  s_tuser,  // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] plane_word, [29:16] word_address, [31:30] zero
	output logic [2:0]  m_tuser,  // [1:0] plane_number, [2] frame_end
	output logic        m_tlast
);

	localparam int CW = cpm_pkg::COL_W;
	localparam int RW = cpm_pkg::ROW_W;
	localparam int AW = cpm_pkg::ADDR_W;
	localparam int WW = cpm_pkg::WORD_W;
	localparam int KW = cpm_pkg::COLOR_W;
	localparam int PW = cpm_pkg::PIX_W;
	localparam int NP = cpm_pkg::PLANES;
	localparam int GW = CW - 4;

	// Configuration registers
	logic [CW-1:0] frame_width_q;
	logic [RW-1:0] frame_height_q;
	logic [CW-1:0] w_eff;
	logic [RW-1:0] h_eff;

	// Input stage
	logic          valid_s1;
	logic [1:0]    cmd_s1;
	logic [PW-1:0] pix_s1;
	logic [KW-1:0] color_in_s1;
	logic          fwd_hit_s1;
	logic [KW-1:0] fwd_color_s1;

	// Frame state
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] row_base_q;
	logic [WW-1:0] acc_q [NP];
	logic [cpm_pkg::MAP_DEPTH-1:0] map_valid_q;

	// Output burst buffer
	logic          burst_valid_q;
	logic [1:0]    burst_idx_q;
	logic [WW-1:0] burst_word_q [NP];
	logic [AW-1:0] burst_base_q;
	logic          burst_final_q;

	logic [KW-1:0] ram_rdata;
	logic [KW-1:0] color_s1;
	logic [WW-1:0] acc_next [NP];
	logic [WW-1:0] bit_mask;
	logic [GW-1:0] grp;
	logic [GW-1:0] groups;
	logic          is_pix, take_s1, done_s1, stall_s1, commit, accept;
	logic          last_col, last_row, final_group;
	logic [AW-1:0] out_addr;

	always_comb begin
		w_eff = frame_width_q;
		if (frame_width_q == '0 || frame_width_q > CW'(cpm_pkg::MAX_WIDTH)) begin
			w_eff = CW'(cpm_pkg::MAX_WIDTH);
		end
		h_eff = frame_height_q;
		if (frame_height_q == '0 || {1'b0, frame_height_q} > (RW + 1)'(cpm_pkg::MAX_HEIGHT)) begin
			h_eff = RW'(cpm_pkg::MAX_HEIGHT);
		end
	end

	assign groups   = w_eff[CW-1:4];
	assign grp      = col_q[CW-1:4];
	assign is_pix   = (cmd_s1 == cpm_pkg::CMD_PIXEL);
	assign take_s1  = is_pix && (col_q < {groups, 4'b0000});
	assign done_s1  = take_s1 && (col_q[3:0] == 4'hF);
	assign stall_s1 = valid_s1 && done_s1 && burst_valid_q;
	assign commit   = valid_s1 && !stall_s1;
	assign s_tready = !stall_s1;
	assign accept   = s_tvalid && s_tready;

	assign last_col    = ({1'b0, col_q} + (CW + 1)'(1)) >= {1'b0, w_eff};
	assign last_row    = ({1'b0, row_q} + (RW + 1)'(1)) >= {1'b0, h_eff};
	assign final_group = (grp == groups - GW'(1)) && last_row;

	// A map write committed on the same edge as the next read is not yet visible in
	// the RAM output, so its colour is forwarded.
	always_comb begin
		if (fwd_hit_s1) begin
			color_s1 = fwd_color_s1;
		end else if (map_valid_q[pix_s1]) begin
			color_s1 = ram_rdata;
		end else begin
			color_s1 = pix_s1[KW-1:0];
		end
	end

	assign bit_mask = WW'(16'h8000) >> col_q[3:0];

	always_comb begin
		for (int p = 0; p < NP; p++) begin
			acc_next[p] = (acc_q[p] & ~bit_mask) | (color_s1[p] ? bit_mask : '0);
		end
	end

	cpm_ram #(
		.WIDTH(cpm_pkg::COLOR_W),
		.DEPTH(cpm_pkg::MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (commit && cmd_s1 == cpm_pkg::CMD_MAP_WRITE),
		.waddr(pix_s1),
		.wdata(color_in_s1),
		.re   (accept),
		.raddr(s_tdata[PW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CW'(cpm_pkg::MAX_WIDTH);
			frame_height_q <= RW'(cpm_pkg::MAX_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpm_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				cpm_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= s_tuser;
			pix_s1       <= s_tdata[PW-1:0];
			color_in_s1  <= s_tdata[PW+KW-1:PW];
			fwd_hit_s1   <= commit && cmd_s1 == cpm_pkg::CMD_MAP_WRITE
				&& pix_s1 == s_tdata[PW-1:0];
			fwd_color_s1 <= color_in_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q <= '0;
		end else if (commit) begin
			if (cmd_s1 == cpm_pkg::CMD_MAP_RESTORE) begin
				map_valid_q <= '0;
			end else if (cmd_s1 == cpm_pkg::CMD_MAP_WRITE) begin
				map_valid_q[pix_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			for (int p = 0; p < NP; p++) begin
				acc_q[p] <= '0;
			end
		end else if (cfg_we) begin
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			for (int p = 0; p < NP; p++) begin
				acc_q[p] <= '0;
			end
		end else if (commit && is_pix) begin
			if (take_s1) begin
				for (int p = 0; p < NP; p++) begin
					acc_q[p] <= done_s1 ? '0 : acc_next[p];
				end
			end
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q      <= '0;
					row_base_q <= '0;
				end else begin
					row_q      <= row_q + RW'(1);
					row_base_q <= row_base_q + AW'(w_eff[CW-1:2]);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_q <= 1'b0;
			burst_idx_q   <= '0;
		end else if (commit && done_s1) begin
			burst_valid_q <= 1'b1;
			burst_idx_q   <= '0;
		end else if (m_tvalid && m_tready) begin
			if (burst_idx_q == 2'd3) begin
				burst_valid_q <= 1'b0;
			end
			burst_idx_q <= burst_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && done_s1) begin
			for (int p = 0; p < NP; p++) begin
				burst_word_q[p] <= acc_next[p];
			end
			burst_base_q  <= row_base_q + AW'({grp, 2'b00});
			burst_final_q <= final_group;
		end
	end

	assign out_addr = burst_base_q + AW'(burst_idx_q);
	assign m_tvalid = burst_valid_q;
	assign m_tdata  = {2'b00, out_addr, burst_word_q[burst_idx_q]};
	assign m_tlast  = (burst_idx_q == 2'd3);
	assign m_tuser  = {burst_final_q && m_tlast, burst_idx_q};

	`CPM_ASSERT_IMPLY(a_no_burst_overrun, clk, arst_n, commit && done_s1, !burst_valid_q,
		"group completed while the previous burst was still pending")
	`CPM_ASSERT_IMPLY(a_column_in_row, clk, arst_n, 1'b1, col_q < w_eff,
		"column count reached the effective width")
	`CPM_ASSERT_NEXT(a_burst_ends, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid,
		"burst buffer still valid after its fourth word")
	`CPM_ASSERT_NEXT(a_stall_holds_item, clk, arst_n, valid_s1 && !s_tready,
		valid_s1 && $stable(pix_s1) && $stable(cmd_s1), "stalled input stage lost its item")

endmodule
